[rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is held
`define UIW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked property that is also checked during reset
`define UIW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

[rtl/uiw_pkg.sv]
package uiw_pkg;

    localparam int ID_W        = 64;
    localparam int DEPTH_DEF   = 64;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 3;
    localparam int CNT_OUT_W   = 7;

    // input tdata layout
    localparam int IN_SKIP_BIT = ID_W;
    localparam int IN_MARK_LSB = ID_W + 1;
    localparam int IN_DATA_W   = 136;

    // output tdata layout
    localparam int OUT_DATA_W  = ID_W + 1 + CNT_OUT_W;

    typedef enum logic [OP_W-1:0] {
        OP_DELIVER = 2'd0,
        OP_ACK     = 2'd1,
        OP_READ    = 2'd2,
        OP_MARK    = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 3'd0,
        ST_ZERO     = 3'd1,
        ST_DUP      = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } t_cell_op;

    typedef struct packed {
        logic     capture;
        t_cell_op cell_op;
    } t_cell_ctl;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_APPLY = 1'b1
    } t_state;

endpackage

[rtl/uiw_cell.sv]
module uiw_cell
    import uiw_pkg::*;
(
    input  logic            i_clk,
    input  t_cell_ctl       i_ctl,
    input  logic            i_valid,
    input  logic [ID_W-1:0] i_id,
    input  logic [ID_W-1:0] i_left_val,
    input  logic            i_left_gt,
    input  logic [ID_W-1:0] i_right_val,
    output logic [ID_W-1:0] o_val,
    output logic            o_gt,
    output logic            o_eq
);

    logic [ID_W-1:0] r_val;
    logic [ID_W-1:0] n_val;
    logic            r_gt;
    logic            r_eq;

    // empty cells count as greater so they take part in shifts
    always_comb begin
        case (i_ctl.cell_op)
            CELL_INSERT: begin
                n_val = r_gt ? (i_left_gt ? i_left_val : i_id) : r_val;
            end
            CELL_REMOVE: begin
                n_val = (r_gt || r_eq) ? i_right_val : r_val;
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (i_ctl.capture) begin
            r_gt <= !i_valid || (r_val > i_id);
            r_eq <= i_valid && (r_val == i_id);
        end
    end

    assign o_val = r_val;
    assign o_gt  = r_gt;
    assign o_eq  = r_eq;

endmodule

[rtl/uiw_chain.sv]
module uiw_chain
    import uiw_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEF,
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [CNT_W-1:0] i_count,
    input  logic [ID_W-1:0]  i_id,
    output logic             o_found,
    output logic [ID_W-1:0]  o_head_next
);

    logic [ID_W-1:0]        w_val [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_gt;
    logic [TABLE_DEPTH-1:0] w_eq;
    logic [TABLE_DEPTH-1:0] w_valid;

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        logic [ID_W-1:0] w_left_val;
        logic            w_left_gt;
        logic [ID_W-1:0] w_right_val;

        assign w_valid[i] = (CNT_W'(i) < i_count);

        if (i == 0) begin : g_first
            assign w_left_val = '0;
            assign w_left_gt  = 1'b0;
        end else begin : g_inner
            assign w_left_val = w_val[i-1];
            assign w_left_gt  = w_gt[i-1];
        end

        if (i == TABLE_DEPTH - 1) begin : g_last
            assign w_right_val = w_val[i];
        end else begin : g_body
            assign w_right_val = w_val[i+1];
        end

        uiw_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (i_ctl),
            .i_valid     (w_valid[i]),
            .i_id        (i_id),
            .i_left_val  (w_left_val),
            .i_left_gt   (w_left_gt),
            .i_right_val (w_right_val),
            .o_val       (w_val[i]),
            .o_gt        (w_gt[i]),
            .o_eq        (w_eq[i])
        );
    end

    // the table holds no duplicates, so at most one flag is set
    assign o_found = |w_eq;

    // what the head cell will hold after this cycle
    always_comb begin
        case (i_ctl.cell_op)
            CELL_INSERT: begin
                o_head_next = w_gt[0] ? i_id : w_val[0];
            end
            CELL_REMOVE: begin
                o_head_next = (w_gt[0] || w_eq[0]) ? w_val[1] : w_val[0];
            end
            default: begin
                o_head_next = w_val[0];
            end
        endcase
    end

endmodule

[rtl/unacked_id_tracker_watermark.sv]
// Tracks delivered but not yet acknowledged message ids in a sorted row of
// TABLE_DEPTH cells, each holding one id, and reports the consume watermark
// (oldest unacked id minus one, or the highest delivered id when nothing is
// held) with every result. Each transfer is handled in order: when it is
// accepted in S_IDLE every cell compares its id against the broadcast one,
// then in S_APPLY, once the output register is free, the row shifts one place
// to insert or remove and the result is written to the output register. A new
// transfer is taken only after the FSM returns to S_IDLE, so the block never
// takes one before the last is through, and waits while a result is not taken.
module unacked_id_tracker_watermark
    import uiw_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave side
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [63:0] msg_id, [64] skip_ack, [128:65] replicated_mark
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] operation
    input  logic [OP_W-1:0]       s_axis_tuser,
    // master side
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [63:0] watermark, [64] advanced, [71:65] pending_count
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [2:0] status
    output logic [STATUS_W-1:0]   m_axis_tuser
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int EXT_W = CNT_W + CNT_OUT_W;

    // fsm
    t_state r_state;
    t_state n_state;

    // transfer held while the row works on it
    t_op             r_op;
    logic [ID_W-1:0] r_id;
    logic            r_skip;
    logic [ID_W-1:0] r_mark;

    // tracker state
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [ID_W-1:0]  r_highest;
    logic [ID_W-1:0]  n_highest;
    logic [ID_W-1:0]  r_repl;
    logic [ID_W-1:0]  n_repl;

    // output register
    logic                 r_out_valid;
    t_status              r_status;
    logic [ID_W-1:0]      r_wm;
    logic                 r_adv;
    logic [CNT_OUT_W-1:0] r_pend;

    logic            w_accept;
    logic            w_out_free;
    logic            w_apply;
    t_cell_ctl       w_ctl;
    t_cell_op        w_cell_op;
    logic [ID_W-1:0] w_cell_id;
    logic            w_found;
    logic [ID_W-1:0] w_head_next;
    t_status         w_status;
    logic            w_adv;
    logic [ID_W-1:0] w_wm;
    logic [EXT_W-1:0] w_count_ext;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb begin
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                w_apply       = 1'b0;
            end
            S_APPLY: begin
                s_axis_tready = 1'b0;
                w_apply       = w_out_free;
            end
            default: begin
                s_axis_tready = 1'b0;
                w_apply       = 1'b0;
            end
        endcase
    end

    // operation decode, only acted on in the shift cycle
    always_comb begin
        n_count   = r_count;
        n_highest = r_highest;
        n_repl    = r_repl;
        w_cell_op = CELL_HOLD;
        w_status  = ST_DONE;
        w_adv     = 1'b0;
        if (w_apply) begin
            case (r_op)
                OP_DELIVER: begin
                    if (r_id == '0) begin
                        w_status = ST_ZERO;
                    end else begin
                        if (r_id > r_highest) begin
                            n_highest = r_id;
                        end
                        // duplicate wins over full
                        if (!r_skip) begin
                            if (w_found) begin
                                w_status = ST_DUP;
                            end else if (r_count == CNT_W'(TABLE_DEPTH)) begin
                                w_status = ST_FULL;
                            end else begin
                                w_cell_op = CELL_INSERT;
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                    end
                end
                OP_ACK: begin
                    if (r_id == '0) begin
                        w_status = ST_ZERO;
                    end else if (w_found) begin
                        w_cell_op = CELL_REMOVE;
                        n_count   = r_count - CNT_W'(1);
                    end else begin
                        w_status = ST_NOTFOUND;
                    end
                end
                OP_MARK: begin
                    if (r_mark > r_repl) begin
                        n_repl = r_mark;
                        w_adv  = 1'b1;
                    end
                end
                default: begin
                    // read watermark changes nothing
                end
            endcase
        end
    end

    // compare against the new id on accept, insert the held id when shifting
    assign w_cell_id     = w_accept ? s_axis_tdata[ID_W-1:0] : r_id;
    assign w_ctl.capture = w_accept;
    assign w_ctl.cell_op = w_cell_op;

    uiw_chain #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_chain (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_count     (r_count),
        .i_id        (w_cell_id),
        .o_found     (w_found),
        .o_head_next (w_head_next)
    );

    // watermark as it stands after this transfer
    assign w_wm        = (n_count != '0) ? (w_head_next - ID_W'(1)) : n_highest;
    assign w_count_ext = EXT_W'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_highest   <= '0;
            r_repl      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_highest <= n_highest;
            r_repl    <= n_repl;
            if (w_apply) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= t_op'(s_axis_tuser);
            r_id   <= s_axis_tdata[ID_W-1:0];
            r_skip <= s_axis_tdata[IN_SKIP_BIT];
            r_mark <= s_axis_tdata[IN_MARK_LSB +: ID_W];
        end
        if (w_apply) begin
            r_status <= w_status;
            r_wm     <= w_wm;
            r_adv    <= w_adv;
            r_pend   <= w_count_ext[CNT_OUT_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_pend, r_adv, r_wm};
    assign m_axis_tuser  = r_status;

endmodule

[rtl/uiw_checker.sv]
`include "assert_macros.svh"

module uiw_checker
    import uiw_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic [OP_W-1:0]       s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [STATUS_W-1:0]   m_axis_tuser
);

    // a stalled result holds still
    `UIW_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // the row must shift before it takes more, so no transfer right after another
    `UIW_ASSERT(a_one_in_flight, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while row busy")

    // only a mark can report an advance, and it always answers done
    `UIW_ASSERT(a_adv_done, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[ID_W] |-> m_axis_tuser == ST_DONE, "advance with non-done status")

    // no result straight out of reset
    `UIW_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind unacked_id_tracker_watermark uiw_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
